// File: src/lmms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_pkg
// Shared types and constants for the lattice melt step core.
// ----------------------------------------------------------------------------
package lmms_pkg;

  localparam int DIM_X  = 16;
  localparam int DIM_Y  = 16;
  localparam int DIM_Z  = 16;
  localparam int NCELLS = DIM_X * DIM_Y * DIM_Z;
  localparam int DIM_YZ = DIM_Y * DIM_Z;

  localparam int AW = $clog2(NCELLS);
  localparam int XW = $clog2(DIM_X);
  localparam int YW = $clog2(DIM_Y);
  localparam int ZW = $clog2(DIM_Z);
  localparam int CW = 6;
  localparam int WW = 16;
  localparam int AccW = WW + 3;
  localparam int TW = $clog2(longint'(NCELLS) * 6 * 65536);
  localparam int RW = 32;
  localparam int OTW = 31;
  localparam longint TOTAL_MAX = 64'h7FFF_FFFF;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_MELT  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] CELL_AIR   = 2'd0;
  localparam logic [1:0] CELL_ICE   = 2'd1;
  localparam logic [1:0] CELL_WATER = 2'd2;
  localparam logic [1:0] CELL_BAD   = 2'd3;

  localparam logic [1:0] REG_WEIGHT_AIR   = 2'd0;
  localparam logic [1:0] REG_WEIGHT_ICE   = 2'd1;
  localparam logic [1:0] REG_WEIGHT_WATER = 2'd2;

  localparam logic [WW-1:0] RST_WEIGHT_AIR   = 16'd4096;
  localparam logic [WW-1:0] RST_WEIGHT_ICE   = 16'd0;
  localparam logic [WW-1:0] RST_WEIGHT_WATER = 16'd410;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RW_RD, ST_RW_OUT,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_THR
  } state_t;

  typedef struct packed {
    logic       clr_wr;
    logic       latch;
    logic       rw_rd;
    logic       rw_out;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       acc_first;
    logic       acc_add;
    logic       apply;
    logic       thr_load;
  } cmd_t;

  typedef struct packed {
    logic       last_cell;
    logic [1:0] mode;
    logic       pass;
    logic       hit;
    logic       tot_zero;
  } stat_t;

endpackage

// File: src/lmms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_ctrl
// Sequencer: memory clear, cell read/write, and the two lattice passes.
// ----------------------------------------------------------------------------
module lmms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lmms_pkg::stat_t stat,
  output lmms_pkg::cmd_t  cmd,
  output logic           busy
);
  import lmms_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.last_cell) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (stat.mode == MODE_MELT) state_next = ST_P0;
          else state_next = ST_RW_RD;
        end
      end
      ST_RW_RD:  state_next = ST_RW_OUT;
      ST_RW_OUT: state_next = ST_IDLE;
      ST_P0:     state_next = ST_P1;
      ST_P1:     state_next = ST_P2;
      ST_P2:     state_next = ST_P3;
      ST_P3:     state_next = ST_P4;
      ST_P4: begin
        if (stat.pass) begin
          if (stat.hit || stat.last_cell) state_next = ST_IDLE;
          else state_next = ST_P0;
        end else begin
          if (stat.last_cell) state_next = ST_THR;
          else state_next = ST_P0;
        end
      end
      ST_THR: begin
        if (stat.tot_zero) state_next = ST_IDLE;
        else state_next = ST_P0;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR:  cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_RW_RD:  cmd.rw_rd = 1'b1;
      ST_RW_OUT: cmd.rw_out = 1'b1;
      ST_P0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
      end
      ST_P1: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = 2'd1;
        cmd.acc_first = 1'b1;
      end
      ST_P2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 2'd2;
        cmd.acc_add = 1'b1;
      end
      ST_P3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = 2'd3;
        cmd.acc_add = 1'b1;
      end
      ST_P4:  cmd.apply = 1'b1;
      ST_THR: cmd.thr_load = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/lmms_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_dp
// Cell store, weight registers, neighbor weight accumulation, total,
// threshold multiply, cumulative search and result registers.
// ----------------------------------------------------------------------------
module lmms_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  lmms_pkg::cmd_t            cmd,
  output lmms_pkg::stat_t           stat,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [lmms_pkg::WW-1:0]   cfg_data,
  input  logic [1:0]                mode,
  input  logic [lmms_pkg::CW-1:0]   cell_x,
  input  logic [lmms_pkg::CW-1:0]   cell_y,
  input  logic [lmms_pkg::CW-1:0]   cell_z,
  input  logic [1:0]                new_state,
  input  logic [lmms_pkg::RW-1:0]   random_fraction,
  output logic                      done,
  output logic [lmms_pkg::CW-1:0]   out_x,
  output logic [lmms_pkg::CW-1:0]   out_y,
  output logic [lmms_pkg::CW-1:0]   out_z,
  output logic [1:0]                cell_state,
  output logic                      did_melt,
  output logic [lmms_pkg::OTW-1:0]  total_weight
);
  import lmms_pkg::*;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    cell_addr = AW'(32'(x) * 32'(DIM_YZ) + 32'(y) * 32'(DIM_Z) + 32'(z));
  endfunction

  logic [WW-1:0] w_air, w_ice, w_water;

  function automatic logic [AccW-1:0] sw(input logic [1:0] s,
                                         input logic [WW-1:0] wa,
                                         input logic [WW-1:0] wi,
                                         input logic [WW-1:0] wt);
    case (s)
      CELL_AIR:   sw = AccW'(wa);
      CELL_ICE:   sw = AccW'(wi);
      CELL_WATER: sw = AccW'(wt);
      default:    sw = '0;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      w_air   <= RST_WEIGHT_AIR;
      w_ice   <= RST_WEIGHT_ICE;
      w_water <= RST_WEIGHT_WATER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_AIR:   w_air   <= cfg_data;
        REG_WEIGHT_ICE:   w_ice   <= cfg_data;
        REG_WEIGHT_WATER: w_water <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]    mode_q, ns_q;
  logic [CW-1:0] x_q, y_q, z_q;
  logic [RW-1:0] r_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= mode;
      x_q    <= cell_x;
      y_q    <= cell_y;
      z_q    <= cell_z;
      ns_q   <= new_state;
      r_q    <= random_fraction;
    end
  end

  logic in_range;
  assign in_range = ({1'b0, x_q} < 7'(DIM_X)) && ({1'b0, y_q} < 7'(DIM_Y)) &&
                    ({1'b0, z_q} < 7'(DIM_Z));

  // scan counters
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [ZW-1:0] cz;
  logic          cnt_inc, cnt_clr, last_cell;

  assign last_cell = (cx == XW'(DIM_X - 1)) && (cy == YW'(DIM_Y - 1)) &&
                     (cz == ZW'(DIM_Z - 1));
  assign cnt_inc   = cmd.clr_wr || cmd.apply;

  logic pass;
  assign cnt_clr = cmd.latch || (cmd.thr_load && !stat.tot_zero);

  always_ff @(posedge clk) begin
    if (rst || cnt_clr) begin
      cx <= '0;
      cy <= '0;
      cz <= '0;
    end else if (cnt_inc) begin
      if (cz == ZW'(DIM_Z - 1)) begin
        cz <= '0;
        if (cy == YW'(DIM_Y - 1)) begin
          cy <= '0;
          cx <= (cx == XW'(DIM_X - 1)) ? '0 : cx + 1'b1;
        end else begin
          cy <= cy + 1'b1;
        end
      end else begin
        cz <= cz + 1'b1;
      end
    end
  end

  logic [AW-1:0] ca;
  logic          interior;
  assign ca = cell_addr(CW'(cx), CW'(cy), CW'(cz));
  assign interior = (cx != '0) && (cy != '0) && (cz != '0) &&
                    (cx != XW'(DIM_X - 1)) && (cy != YW'(DIM_Y - 1)) &&
                    (cz != ZW'(DIM_Z - 1));

  // cell store
  logic [1:0]    mem [NCELLS];
  logic [AW-1:0] ra, rb, wa;
  logic [1:0]    rd_a, rd_b, wd;
  logic          we;

  always_comb begin
    ra = ca;
    rb = ca;
    if (cmd.rw_rd) begin
      ra = in_range ? cell_addr(x_q, y_q, z_q) : '0;
    end else if (interior && cmd.rd_en) begin
      case (cmd.rd_sel)
        2'd0: begin
          ra = ca;
          rb = ca + AW'(DIM_YZ);
        end
        2'd1: begin
          ra = ca - AW'(DIM_YZ);
          rb = ca + AW'(DIM_Z);
        end
        2'd2: begin
          ra = ca - AW'(DIM_Z);
          rb = ca + AW'(1);
        end
        default: begin
          ra = ca - AW'(1);
          rb = ca - AW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // weight accumulation
  logic [1:0]      center;
  logic [AccW-1:0] acc, w_cell;

  always_ff @(posedge clk) begin
    if (cmd.acc_first) begin
      center <= rd_a;
      acc    <= sw(rd_b, w_air, w_ice, w_water);
    end else if (cmd.acc_add) begin
      acc <= acc + sw(rd_a, w_air, w_ice, w_water) + sw(rd_b, w_air, w_ice, w_water);
    end
  end

  assign w_cell = (interior && center == CELL_ICE) ?
                  acc + sw(rd_a, w_air, w_ice, w_water) : '0;

  // total, threshold, cumulative search
  logic [TW-1:0]    total, cum, thr, cum_next;
  logic [TW+RW-1:0] prod;
  logic             hit;

  assign cum_next = cum + TW'(w_cell);
  assign hit      = cum_next > thr;
  assign thr      = prod[TW+RW-1:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= 1'b0;
    end else if (cmd.latch) begin
      pass <= 1'b0;
    end else if (cmd.thr_load) begin
      pass <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      total <= '0;
      cum   <= '0;
    end else if (cmd.apply) begin
      if (pass) cum <= cum_next;
      else total <= total + TW'(w_cell);
    end
    if (cmd.thr_load) prod <= (TW + RW)'(total) * (TW + RW)'(r_q);
  end

  logic [63:0]    tot64;
  logic [OTW-1:0] tot_sat;
  assign tot64   = 64'(total);
  assign tot_sat = (tot64 > 64'(TOTAL_MAX)) ? OTW'(TOTAL_MAX) : tot64[OTW-1:0];

  logic rw_wr;
  assign rw_wr = cmd.rw_out && mode_q == MODE_WRITE && in_range && ns_q != CELL_BAD;

  always_comb begin
    we = 1'b0;
    wa = ca;
    wd = CELL_AIR;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (rw_wr) begin
      we = 1'b1;
      wa = cell_addr(x_q, y_q, z_q);
      wd = ns_q;
    end else if (cmd.apply && pass && hit) begin
      we = 1'b1;
      wd = CELL_WATER;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.rw_out || (cmd.apply && pass && (hit || last_cell)) ||
              (cmd.thr_load && stat.tot_zero);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rw_out) begin
      did_melt     <= 1'b0;
      total_weight <= '0;
      if (mode_q == MODE_WRITE || mode_q == MODE_READ) begin
        out_x      <= x_q;
        out_y      <= y_q;
        out_z      <= z_q;
        cell_state <= !in_range ? CELL_AIR : (rw_wr ? ns_q : rd_a);
      end else begin
        out_x      <= '0;
        out_y      <= '0;
        out_z      <= '0;
        cell_state <= CELL_AIR;
      end
    end else if (cmd.thr_load && stat.tot_zero) begin
      out_x        <= '0;
      out_y        <= '0;
      out_z        <= '0;
      cell_state   <= CELL_AIR;
      did_melt     <= 1'b0;
      total_weight <= '0;
    end else if (cmd.apply && pass && (hit || last_cell)) begin
      total_weight <= tot_sat;
      if (hit) begin
        out_x      <= CW'(cx);
        out_y      <= CW'(cy);
        out_z      <= CW'(cz);
        cell_state <= center;
        did_melt   <= 1'b1;
      end else begin
        out_x      <= '0;
        out_y      <= '0;
        out_z      <= '0;
        cell_state <= CELL_AIR;
        did_melt   <= 1'b0;
      end
    end
  end

  assign stat.last_cell = last_cell;
  assign stat.mode      = mode;
  assign stat.pass      = pass;
  assign stat.hit       = hit;
  assign stat.tot_zero  = (total == '0);

endmodule

// File: src/lattice_melt_monte_carlo_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_melt_monte_carlo_step_core
// 3D air/ice/water lattice with cell read, cell write and one melt step.
// ----------------------------------------------------------------------------
// After reset the core clears the 4096-cell store to air, one cell a cycle,
// and keeps busy high until the clear is done. A cell read or write goes
// from start through states RW_RD and RW_OUT to the registered done strobe;
// mode 3 takes the same path. A melt step walks the lattice twice, through
// states P0 to P4 for each cell (the store has two read ports and each cell
// needs itself plus six neighbors): one walk for the weight total, then the
// threshold multiply, then a second walk for the search, ending early at the
// melted cell. A zero total ends after the first walk. done is high for
// exactly one cycle with the result; the receiver cannot stall it. Weight
// registers may be written whenever the core is idle; cfg_ready is always high.
module lattice_melt_monte_carlo_step_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic [lmms_pkg::CW-1:0]  cell_x,
  input  logic [lmms_pkg::CW-1:0]  cell_y,
  input  logic [lmms_pkg::CW-1:0]  cell_z,
  input  logic [1:0]               new_state,
  input  logic [lmms_pkg::RW-1:0]  random_fraction,
  output logic                     done,
  output logic [lmms_pkg::CW-1:0]  out_x,
  output logic [lmms_pkg::CW-1:0]  out_y,
  output logic [lmms_pkg::CW-1:0]  out_z,
  output logic [1:0]               cell_state,
  output logic                     did_melt,
  output logic [lmms_pkg::OTW-1:0] total_weight,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [lmms_pkg::WW-1:0]  cfg_data
);
  import lmms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  lmms_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lmms_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .cell_z          (cell_z),
    .new_state       (new_state),
    .random_fraction (random_fraction),
    .done            (done),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .cell_state      (cell_state),
    .did_melt        (did_melt),
    .total_weight    (total_weight)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_melt_ice: assert property (@(posedge clk) disable iff (rst)
    done && did_melt |-> cell_state == CELL_ICE && total_weight != '0)
    else $error("melted cell was not ice or total is zero");

endmodule

// File: bench/lattice_melt_monte_carlo_step_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_melt_monte_carlo_step_core_tb
// Self-checking bench for the lattice melt step core.
// ----------------------------------------------------------------------------
// A shadow lattice and shadow weight registers predict every cell write, cell
// read and melt step. Directed items hit the faces, out-of-range coordinates,
// the bad state code, mode 3 and zero-total melts. Random segments then build
// ice clusters and melt them under two weight settings (all max, then random).
// ----------------------------------------------------------------------------
module lattice_melt_monte_carlo_step_core_tb;
  import lmms_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 12;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} entry_kind_t;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    entry_kind_t kind;
    logic [1:0]  mode;
    logic [5:0]  x, y, z;
    logic [1:0]  ns;
    logic [31:0] rf;
    logic [1:0]  idx;
    logic [15:0] data;
  } entry_t;

  typedef struct {
    logic [5:0]  x, y, z;
    logic [1:0]  st;
    logic        melt;
    logic [30:0] total;
  } result_t;

  logic clk = 0, rst = 1;
  logic start = 0, busy, done;
  logic [1:0] mode = 0, new_state = 0, cell_state;
  logic [5:0] cell_x = 0, cell_y = 0, cell_z = 0, out_x, out_y, out_z;
  logic [31:0] random_fraction = 0;
  logic did_melt;
  logic [30:0] total_weight;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  lattice_melt_monte_carlo_step_core u_top (.*);

  always #1 clk = ~clk;

  entry_t    stim_q[$];
  result_t   pending_results[$];
  logic [1:0] lat [DIM_X][DIM_Y][DIM_Z];
  logic [15:0] w_air = RST_WEIGHT_AIR, w_ice = RST_WEIGHT_ICE, w_water = RST_WEIGHT_WATER;
  int errors = 0, n_items = 0, n_melt_steps = 0, n_melted = 0;
  int idle_cycles = 0, gap = 0;
  bit item_taken = 0, cfg_taken = 0;

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic longint unsigned neighbor_weight(logic [1:0] s);
    case (s)
      CELL_AIR:   return w_air;
      CELL_ICE:   return w_ice;
      CELL_WATER: return w_water;
      default:    return 0;
    endcase
  endfunction

  function automatic longint unsigned melt_weight(int x, int y, int z);
    if (x == 0 || y == 0 || z == 0 || x == DIM_X - 1 || y == DIM_Y - 1 || z == DIM_Z - 1)
      return 0;
    if (lat[x][y][z] != CELL_ICE) return 0;
    return neighbor_weight(lat[x+1][y][z]) + neighbor_weight(lat[x-1][y][z]) +
           neighbor_weight(lat[x][y+1][z]) + neighbor_weight(lat[x][y-1][z]) +
           neighbor_weight(lat[x][y][z+1]) + neighbor_weight(lat[x][y][z-1]);
  endfunction

  function automatic result_t predict_cell_op(entry_t e);
    result_t r;
    longint unsigned total, cum;
    logic [63:0] thr;
    r = '{x: 0, y: 0, z: 0, st: 0, melt: 0, total: 0};
    if (e.mode == MODE_WRITE || e.mode == MODE_READ) begin
      r.x = e.x; r.y = e.y; r.z = e.z;
      if (e.x < DIM_X && e.y < DIM_Y && e.z < DIM_Z) begin
        if (e.mode == MODE_WRITE && e.ns != CELL_BAD) lat[e.x][e.y][e.z] = e.ns;
        r.st = lat[e.x][e.y][e.z];
      end
    end else if (e.mode == MODE_MELT) begin
      total = 0;
      foreach (lat[i, j, k]) total += melt_weight(i, j, k);
      r.total = (total > TOTAL_MAX) ? 31'h7FFF_FFFF : total[30:0];
      if (total != 0) begin
        thr = (64'(total) * 64'(e.rf)) >> 32;
        cum = 0;
        for (int i = 0; i < DIM_X; i++)
          for (int j = 0; j < DIM_Y; j++)
            for (int k = 0; k < DIM_Z; k++) begin
              cum += melt_weight(i, j, k);
              if (cum > thr && !r.melt) begin
                r.x = 6'(i); r.y = 6'(j); r.z = 6'(k);
                r.st = lat[i][j][k];
                r.melt = 1;
                lat[i][j][k] = CELL_WATER;
              end
            end
      end
    end
    return r;
  endfunction

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    result_t want;
    item_taken = start && !busy && !rst;
    cfg_taken = cfg_valid && cfg_ready && !rst;
    if (done && !rst) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_x !== want.x) report("out_x", out_x, want.x);
        if (out_y !== want.y) report("out_y", out_y, want.y);
        if (out_z !== want.z) report("out_z", out_z, want.z);
        if (cell_state !== want.st) report("cell_state", cell_state, want.st);
        if (did_melt !== want.melt) report("did_melt", did_melt, want.melt);
        if (total_weight !== want.total) report("total_weight", total_weight, want.total);
        if (want.melt) n_melted++;
      end
    end
    if (item_taken) begin
      entry_t e;
      e.mode = mode; e.x = cell_x; e.y = cell_y; e.z = cell_z;
      e.ns = new_state; e.rf = random_fraction;
      pending_results.push_back(predict_cell_op(e));
      n_items++;
      if (mode == MODE_MELT) n_melt_steps++;
    end
    if (cfg_taken) begin
      case (cfg_index)
        REG_WEIGHT_AIR:   w_air = cfg_data;
        REG_WEIGHT_ICE:   w_ice = cfg_data;
        REG_WEIGHT_WATER: w_water = cfg_data;
        default: ;
      endcase
    end
    if (item_taken || cfg_taken || done || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (start) begin
        if (item_taken) begin
          start <= 0;
          gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        end
      end else if (cfg_valid) begin
        if (cfg_taken) cfg_valid <= 0;
      end else if (gap > 0) begin
        gap--;
      end else if (stim_q.size() > 0) begin
        case (stim_q[0].kind)
          K_ITEM: begin
            mode <= stim_q[0].mode; cell_x <= stim_q[0].x; cell_y <= stim_q[0].y;
            cell_z <= stim_q[0].z; new_state <= stim_q[0].ns;
            random_fraction <= stim_q[0].rf;
            start <= 1;
            void'(stim_q.pop_front());
          end
          K_CFG: begin
            cfg_index <= stim_q[0].idx; cfg_data <= stim_q[0].data;
            cfg_valid <= 1;
            void'(stim_q.pop_front());
          end
          default: begin
            if (pending_results.size() == 0 && !busy) begin
              gap = SETTLE_CYCLES;
              void'(stim_q.pop_front());
            end
          end
        endcase
      end
    end
  end

  task automatic push_item(logic [1:0] m, int x, int y, int z, int ns, int rf);
    stim_q.push_back('{kind: K_ITEM, mode: m, x: 6'(x), y: 6'(y), z: 6'(z), ns: 2'(ns),
                       rf: 32'(rf), idx: 0, data: 0});
  endtask

  task automatic push_cfg(logic [1:0] idx, int data);
    stim_q.push_back('{kind: K_DRAIN, mode: 0, x: 0, y: 0, z: 0, ns: 0, rf: 0,
                       idx: 0, data: 0});
    stim_q.push_back('{kind: K_CFG, mode: 0, x: 0, y: 0, z: 0, ns: 0, rf: 0,
                       idx: idx, data: 16'(data)});
  endtask

  // one segment: an ice cluster with random content and noise, ending in a melt
  task automatic push_segment();
    int cx, cy, cz, pick;
    cx = $urandom_range(1, 12); cy = $urandom_range(1, 12); cz = $urandom_range(1, 12);
    for (int n = 0; n < 9; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)
        push_item(MODE_WRITE, cx + $urandom_range(0, 3), cy + $urandom_range(0, 3),
                  cz + $urandom_range(0, 3), $urandom_range(0, 5) < 4 ? int'(CELL_ICE)
                  : $urandom_range(0, 3), $urandom);
      else if (pick < 16)
        push_item(MODE_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom, $urandom);
      else if (pick < 17)
        push_item(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        push_item(2'($urandom_range(0, 1)) << 1, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    end
    push_item(MODE_MELT, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;

    push_item(MODE_MELT, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push_item(MODE_READ, 0, 0, 0, 0, 0);
    push_item(MODE_WRITE, 0, 0, 0, CELL_ICE, 0);
    push_item(MODE_WRITE, 15, 15, 15, CELL_ICE, 0);
    push_item(MODE_WRITE, 63, 63, 63, CELL_ICE, 0);
    push_item(MODE_READ, 63, 5, 5, 0, 0);
    push_item(MODE_WRITE, 5, 5, 5, CELL_ICE, 0);
    push_item(MODE_WRITE, 5, 5, 5, CELL_BAD, 0);
    push_item(MODE_WRITE, 5, 5, 6, CELL_ICE, 0);
    push_item(MODE_WRITE, 5, 6, 5, CELL_WATER, 0);
    push_item(MODE_WRITE, 14, 14, 14, CELL_ICE, 0);
    push_item(MODE_WRITE, 1, 1, 1, CELL_ICE, 0);
    push_item(MODE_NONE, 63, 63, 63, CELL_BAD, 32'hFFFF_FFFF);
    push_item(MODE_MELT, 0, 0, 0, 0, 0);
    push_item(MODE_MELT, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push_item(MODE_READ, 5, 5, 5, 0, 0);
    push_item(MODE_WRITE, 15, 0, 63, CELL_AIR, 0);
    push_item(MODE_READ, 14, 14, 14, 0, 0);

    push_cfg(REG_WEIGHT_AIR, 0);
    push_cfg(REG_WEIGHT_ICE, 0);
    push_cfg(REG_WEIGHT_WATER, 0);
    push_item(MODE_MELT, 0, 0, 0, 0, 32'h8000_0000);
    push_cfg(REG_WEIGHT_AIR, 16'hFFFF);
    push_cfg(REG_WEIGHT_ICE, 16'hFFFF);
    push_cfg(REG_WEIGHT_WATER, 16'hFFFF);
    push_item(MODE_MELT, 0, 0, 0, 0, 32'h7FFF_FFFF);
    for (int s = 0; s < 4; s++) push_segment();
    push_cfg(REG_WEIGHT_AIR, $urandom);
    push_cfg(REG_WEIGHT_ICE, $urandom);
    push_cfg(REG_WEIGHT_WATER, $urandom);
    for (int s = 0; s < 4; s++) push_segment();
    push_cfg(REG_WEIGHT_AIR, RST_WEIGHT_AIR);
    push_cfg(REG_WEIGHT_ICE, 16'd2048);
    push_cfg(REG_WEIGHT_WATER, RST_WEIGHT_WATER);
    push_item(MODE_MELT, 0, 0, 0, 0, $urandom);

    wait (stim_q.size() == 0 && !start && !cfg_valid && pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d items, %0d melt steps, %0d cells melted, weights at reset,",
             n_items, n_melt_steps, n_melted);
    $display("all zero, all max and random, plus faces, bad state and out-of-range cells");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lmms_pkg.sv
src/lmms_ctrl.sv
src/lmms_dp.sv
src/lattice_melt_monte_carlo_step_core.sv
bench/lattice_melt_monte_carlo_step_core_tb.sv
